FILE: rtl/core/fbd_pkg.sv
// Shared constants and types of the flag-framed byte destuffer.
package fbd_pkg;

	localparam int FRAME_LEN_W = 10;
	localparam int BYTE_W = 8;
	localparam int unsigned COUNT_MAX_DEFAULT = 1023;
	localparam logic [FRAME_LEN_W-1:0] FRAME_LENGTH_RESET = 10'd256;

	localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7e;
	localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7d;
	localparam logic [BYTE_W-1:0] ESC_FOR_FLAG = 8'h5e;
	localparam logic [BYTE_W-1:0] ESC_FOR_ESC = 8'h5d;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END_OK = 2'd1;
	localparam logic [1:0] KIND_END_BAD = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [BYTE_W-1:0] data_byte;
		logic last;
	} result_t;

	// results produced by one raw byte: num is 0, 1 or 2
	typedef struct packed {
		logic [1:0] num;
		result_t r0;
		result_t r1;
	} dec_t;

endpackage

FILE: rtl/core/fbd_in_stage.sv
// Input register: holds one raw byte until the decode step takes it.
module fbd_in_stage
	import fbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic take,
	output logic valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	logic valid_q;

	assign in_ready = !valid_q || take;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

FILE: rtl/core/fbd_decode.sv
// Frame state and destuffing logic for the byte held in the input register.
module fbd_decode
	import fbd_pkg::*;
#(
	parameter int unsigned COUNT_MAX = COUNT_MAX_DEFAULT
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic take,
	input  logic [FRAME_LEN_W-1:0] frame_length,
	output dec_t dec
);

	localparam int CountW = $clog2(COUNT_MAX + 1);
	localparam int CmpW = (CountW > FRAME_LEN_W) ? CountW : FRAME_LEN_W;

	logic in_frame_q, esc_q;
	logic [CountW-1:0] raw_count_q;
	logic in_frame_d, esc_d;
	logic [CountW-1:0] raw_count_d;
	logic [CountW-1:0] count_bumped;
	logic [1:0] end_kind;
	logic [CmpW-1:0] count_ext, length_ext;

	assign count_bumped = (raw_count_q == CountW'(COUNT_MAX)) ? raw_count_q
		: raw_count_q + 1'b1;
	assign count_ext = CmpW'(raw_count_q);
	assign length_ext = CmpW'(frame_length);
	assign end_kind = (count_ext == length_ext) ? KIND_END_OK : KIND_END_BAD;

	always_comb begin
		dec = '0;
		in_frame_d = in_frame_q;
		esc_d = esc_q;
		raw_count_d = raw_count_q;
		if (!in_frame_q) begin
			if (byte_s1 == FLAG_BYTE) begin
				in_frame_d = 1'b1;
				esc_d = 1'b0;
				raw_count_d = '0;
			end
		end else if (esc_q) begin
			esc_d = 1'b0;
			dec.num = 2'd1;
			dec.r0.kind = KIND_DATA;
			dec.r0.data_byte = ESC_BYTE;
			if (byte_s1 == ESC_FOR_FLAG) begin
				raw_count_d = count_bumped;
				dec.r0.data_byte = FLAG_BYTE;
			end else if (byte_s1 == ESC_FOR_ESC) begin
				raw_count_d = count_bumped;
			end else if (byte_s1 == FLAG_BYTE) begin
				// escape right before the closing flag
				dec.num = 2'd2;
				dec.r1.kind = end_kind;
				in_frame_d = 1'b0;
				raw_count_d = '0;
			end else begin
				// unknown escape: both bytes go out as data
				raw_count_d = count_bumped;
				dec.num = 2'd2;
				dec.r1.kind = KIND_DATA;
				dec.r1.data_byte = byte_s1;
			end
		end else if (byte_s1 == FLAG_BYTE) begin
			dec.num = 2'd1;
			dec.r0.kind = end_kind;
			in_frame_d = 1'b0;
			raw_count_d = '0;
		end else if (byte_s1 == ESC_BYTE) begin
			raw_count_d = count_bumped;
			esc_d = 1'b1;
		end else begin
			raw_count_d = count_bumped;
			dec.num = 2'd1;
			dec.r0.kind = KIND_DATA;
			dec.r0.data_byte = byte_s1;
		end
		dec.r0.last = (dec.num == 2'd1);
		dec.r1.last = (dec.num == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q <= 1'b0;
			raw_count_q <= '0;
		end else if (take) begin
			in_frame_q <= in_frame_d;
			esc_q <= esc_d;
			raw_count_q <= raw_count_d;
		end
	end

	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> in_frame_q)
		else $error("escape pending outside a frame");

	a_count_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (raw_count_q == '0))
		else $error("raw count not cleared outside a frame");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		raw_count_q <= CountW'(COUNT_MAX))
		else $error("raw count beyond its saturation point");

endmodule

FILE: rtl/core/fbd_out_stage.sv
// Result register with a one-entry hold for the second result of a byte.
module fbd_out_stage
	import fbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  dec_t dec,
	output logic take,
	output logic out_valid,
	input  logic out_ready,
	output result_t res
);

	logic out_valid_q, pend_valid_q;
	result_t out_q, pend_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign take = valid_s1 && ((dec.num == 2'd0) || (!pend_valid_q && out_free));
	assign out_valid = out_valid_q;
	assign res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q && out_free) begin
			out_valid_q <= 1'b1;
			pend_valid_q <= 1'b0;
		end else if (take && (dec.num != 2'd0)) begin
			out_valid_q <= 1'b1;
			pend_valid_q <= (dec.num == 2'd2);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end else if (take && (dec.num != 2'd0)) begin
			out_q <= dec.r0;
			pend_q <= dec.r1;
		end
	end

	a_pend_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("held result without a result in the output register");

	a_pend_order: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (!out_q.last && pend_q.last))
		else $error("last flag out of order across a two-result byte");

	a_two_results_held: assert property (@(posedge clk) disable iff (!arst_n)
		(take && dec.num == 2'd2) |=> pend_valid_q)
		else $error("second result of a byte was not held");

endmodule

FILE: rtl/core/flag_framed_byte_destuffer.sv
// Flag-framed byte destuffer: top level.
//
// Raw bytes enter on the in_valid/in_ready channel (rx_byte), one item per
// cycle while in_ready is high. Outside a frame only the flag 0x7e matters;
// it opens a frame. Inside a frame escapes 0x7d 0x5e and 0x7d 0x5d become data
// 0x7e and 0x7d, other bytes pass as data, and the closing flag yields an end
// result (kind 1 when the raw count matched frame_length, kind 2 otherwise).
// Results leave on the out_valid/out_ready channel as kind, data_byte and
// last. Each byte waits in the input register, its results in the output
// register. Throughput is one byte per cycle when not stalled; a byte that
// gives two results holds the input while the single output register drains
// the held second result. frame_length is written over cfg_valid/cfg_ready,
// always ready; the user writes it only while idle; the block does not enforce
// this. Reset puts the block outside a frame with a zero count and
// frame_length 256. When the receiver stalls, the result stays in the output
// register and the next byte that has results waits in the input register
// with in_ready low until out_ready rises; bytes without results still pass.
module flag_framed_byte_destuffer
	import fbd_pkg::*;
#(
	parameter int unsigned COUNT_MAX = COUNT_MAX_DEFAULT
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] kind,
	output logic [BYTE_W-1:0] data_byte,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [FRAME_LEN_W-1:0] frame_length
);

	logic [FRAME_LEN_W-1:0] frame_length_q;
	logic valid_s1, take;
	logic [BYTE_W-1:0] byte_s1;
	dec_t dec;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= FRAME_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frame_length_q <= frame_length;
		end
	end

	fbd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	fbd_decode #(
		.COUNT_MAX (COUNT_MAX)
	) u_dec (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_s1      (byte_s1),
		.take         (take),
		.frame_length (frame_length_q),
		.dec          (dec)
	);

	fbd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.dec       (dec),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign kind = res.kind;
	assign data_byte = res.data_byte;
	assign last = res.last;

endmodule

FILE: tb/flag_framed_byte_destuffer_tb.sv
// Self-checking testbench for the flag-framed byte destuffer.
`timescale 1ns / 1ps

module flag_framed_byte_destuffer_tb;
	import fbd_pkg::*;

	// saturation point of the raw byte count
	localparam int unsigned SAT_MAX = COUNT_MAX_DEFAULT;
	localparam int RAND_TARGET = 1400;
	localparam int HOLD_CYCLES = 80;

	typedef enum logic [1:0] {ROW_BYTE, ROW_CHK, ROW_CFG} row_op_e;

	typedef struct packed {
		row_op_e op;
		logic [FRAME_LEN_W-1:0] val;
		logic [1:0] kind;
		logic [BYTE_W-1:0] data;
	} dir_row_t;

	localparam int DIR_ROWS = 29;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [BYTE_W-1:0] data_byte;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [FRAME_LEN_W-1:0] frame_length = '0;

	// predictor state
	bit pred_in_frame;
	bit pred_esc;
	logic [FRAME_LEN_W-1:0] pred_count;
	logic [FRAME_LEN_W-1:0] pred_len;

	result_t destuffed_q[$];

	int errors;
	int counted;
	int results_seen;
	int ends_ok;
	int ends_bad;
	int cfg_writes;
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	bit hold_req;
	bit hold_used;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_BYTE, 10'h00, KIND_DATA, 8'h00},    // dropped outside a frame
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},    // dropped outside a frame
		'{ROW_BYTE, 10'h7e, KIND_DATA, 8'h00},
		'{ROW_CHK, 10'h7e, KIND_END_BAD, 8'h00},  // empty frame vs reset length
		'{ROW_BYTE, 10'h7e, KIND_DATA, 8'h00},    // closing flag did not reopen
		'{ROW_CHK, 10'h00, KIND_DATA, 8'h00},
		'{ROW_CHK, 10'hff, KIND_DATA, 8'hff},
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},
		'{ROW_CHK, 10'h5e, KIND_DATA, 8'h7e},
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},
		'{ROW_CHK, 10'h5d, KIND_DATA, 8'h7d},
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h41, KIND_DATA, 8'h00},    // unknown escape
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},    // escape followed by escape
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h7e, KIND_DATA, 8'h00},    // escape right before flag
		'{ROW_CFG, 10'd0, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h7e, KIND_DATA, 8'h00},
		'{ROW_CHK, 10'h7e, KIND_END_OK, 8'h00},
		'{ROW_CFG, 10'd1023, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h7e, KIND_DATA, 8'h00},
		'{ROW_CHK, 10'h7e, KIND_END_BAD, 8'h00},
		'{ROW_CFG, 10'd3, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h7e, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h7d, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h5d, KIND_DATA, 8'h00},
		'{ROW_BYTE, 10'h80, KIND_DATA, 8'h00},
		'{ROW_CHK, 10'h7e, KIND_END_OK, 8'h00}
	};

	flag_framed_byte_destuffer #(
		.COUNT_MAX(SAT_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.frame_length(frame_length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("%0t: timeout, %0d results still pending", $time, destuffed_q.size());
		$display("flag_framed_byte_destuffer_tb: done, errors");
		$finish;
	end

	function automatic void bump_count();
		if (pred_count < SAT_MAX)
			pred_count = pred_count + 1'b1;
	endfunction

	// returns the number of results (0..2) one raw byte causes
	function automatic int destuff_predict(input logic [BYTE_W-1:0] b,
			output result_t r0, output result_t r1);
		result_t res [2];
		result_t fin;
		int n;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		fin = '{(pred_count == pred_len) ? KIND_END_OK : KIND_END_BAD, 8'h00, 1'b0};
		if (!pred_in_frame) begin
			if (b == FLAG_BYTE) begin
				pred_in_frame = 1'b1;
				pred_esc = 1'b0;
				pred_count = '0;
			end
		end else if (pred_esc) begin
			pred_esc = 1'b0;
			if (b == ESC_FOR_FLAG) begin
				bump_count();
				res[0] = '{KIND_DATA, FLAG_BYTE, 1'b0};
				n = 1;
			end else if (b == ESC_FOR_ESC) begin
				bump_count();
				res[0] = '{KIND_DATA, ESC_BYTE, 1'b0};
				n = 1;
			end else if (b == FLAG_BYTE) begin
				res[0] = '{KIND_DATA, ESC_BYTE, 1'b0};
				res[1] = fin;
				pred_in_frame = 1'b0;
				pred_count = '0;
				n = 2;
			end else begin
				bump_count();
				res[0] = '{KIND_DATA, ESC_BYTE, 1'b0};
				res[1] = '{KIND_DATA, b, 1'b0};
				n = 2;
			end
		end else if (b == FLAG_BYTE) begin
			res[0] = fin;
			pred_in_frame = 1'b0;
			pred_count = '0;
			n = 1;
		end else if (b == ESC_BYTE) begin
			bump_count();
			pred_esc = 1'b1;
		end else begin
			bump_count();
			res[0] = '{KIND_DATA, b, 1'b0};
			n = 1;
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		r0 = res[0];
		r1 = res[1];
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] ex0,
			input logic [BYTE_W-1:0] ex1, input logic [BYTE_W-1:0] ex2);
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == ex0 || b == ex1 || b == ex2);
		return b;
	endfunction

	// starts just after the clock; returns once the item has been accepted
	task automatic send_rx_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
			input result_t typed_res = '0);
		int gap;
		int n;
		bit counts;
		result_t r0;
		result_t r1;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		counts = pred_in_frame || b == FLAG_BYTE;
		n = destuff_predict(b, r0, r1);
		if (typed) begin
			destuffed_q.push_back(typed_res);
		end else begin
			if (n > 0)
				destuffed_q.push_back(r0);
			if (n > 1)
				destuffed_q.push_back(r1);
		end
		if (counts)
			counted++;
		if (counted == 400 && !hold_used) begin
			hold_req = 1'b1;
			hold_used = 1'b1;
		end
		if ($urandom_range(0, 63) == 0)
			src_idle = !src_idle;
	endtask

	// frame_length only changes once the block has drained
	task automatic set_frame_length(input logic [FRAME_LEN_W-1:0] v);
		in_valid <= 1'b0;
		while (destuffed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		frame_length <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		pred_len = v;
		cfg_writes++;
	endtask

	// receiver: random hold-offs per item, plus one long stall on request
	initial begin
		int gap;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = snk_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			if ($urandom_range(0, 63) == 0)
				snk_idle = !snk_idle;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (destuffed_q.size() == 0) begin
				$display("%0t: unexpected result kind=%0d data=%02h last=%b",
					$time, kind, data_byte, last);
				errors++;
			end else begin
				want = destuffed_q.pop_front();
				if (want.kind !== kind || want.data_byte !== data_byte
						|| want.last !== last) begin
					$display("%0t: mismatch expected kind=%0d data=%02h last=%b,",
						$time, want.kind, want.data_byte, want.last,
						" got kind=%0d data=%02h last=%b", kind, data_byte, last);
					errors++;
				end
				if (want.kind == KIND_END_OK)
					ends_ok++;
				else if (want.kind == KIND_END_BAD)
					ends_bad++;
			end
		end
	end

	initial begin
		int phase;
		int ev;
		int r;
		int c;
		int n;
		int raw;
		int rem;
		bit closed;
		logic [FRAME_LEN_W-1:0] len;
		logic [BYTE_W-1:0] specials [4];

		specials = '{FLAG_BYTE, ESC_BYTE, ESC_FOR_FLAG, ESC_FOR_ESC};
		pred_in_frame = 1'b0;
		pred_esc = 1'b0;
		pred_count = '0;
		pred_len = FRAME_LENGTH_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			case (dir_rows[i].op)
				ROW_CFG: set_frame_length(dir_rows[i].val);
				ROW_CHK: send_rx_byte(dir_rows[i].val[BYTE_W-1:0], 1'b1,
					'{dir_rows[i].kind, dir_rows[i].data, 1'b1});
				default: send_rx_byte(dir_rows[i].val[BYTE_W-1:0]);
			endcase
		end

		phase = 0;
		while (counted < RAND_TARGET) begin
			case (phase % 8)
				0: len = FRAME_LEN_W'(SAT_MAX);
				1: len = 10'd1023;
				2: len = 10'd0;
				3: len = FRAME_LEN_W'($urandom_range(1, 12));
				4: len = 10'd256;
				5: len = FRAME_LEN_W'($urandom_range(0, 1023));
				6: len = 10'd1;
				default: len = FRAME_LEN_W'($urandom_range(2, 20));
			endcase
			set_frame_length(len);
			for (ev = 0; ev < 14 && counted < RAND_TARGET; ev++) begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					if (pred_in_frame)
						send_rx_byte(FLAG_BYTE);
					// one frame around the saturation length can overrun the counter
					if (phase == 0 && ev == 0)
						n = $urandom_range(SAT_MAX - 5, SAT_MAX + 25);
					else if ($urandom_range(0, 1) == 1 && len <= 20)
						n = int'(len);
					else
						n = $urandom_range(0, 14);
					send_rx_byte(FLAG_BYTE);
					raw = 0;
					closed = 1'b0;
					while (raw < n) begin
						rem = n - raw;
						c = $urandom_range(0, 99);
						if (rem >= 2 && c < 16) begin
							send_rx_byte(ESC_BYTE);
							send_rx_byte(c < 8 ? ESC_FOR_FLAG : ESC_FOR_ESC);
							raw += 2;
						end else if (rem >= 2 && c < 22) begin
							send_rx_byte(ESC_BYTE);
							send_rx_byte(pick_byte(ESC_FOR_FLAG, ESC_FOR_ESC, FLAG_BYTE));
							raw += 2;
						end else if (rem == 1 && c < 12) begin
							send_rx_byte(ESC_BYTE);
							send_rx_byte(FLAG_BYTE);
							raw += 1;
							closed = 1'b1;
						end else begin
							send_rx_byte(pick_byte(FLAG_BYTE, ESC_BYTE, FLAG_BYTE));
							raw += 1;
						end
					end
					if (!closed)
						send_rx_byte(FLAG_BYTE);
				end else if (r < 90) begin
					repeat ($urandom_range(1, 6)) begin
						if ($urandom_range(0, 99) < 40)
							send_rx_byte(specials[$urandom_range(0, 3)]);
						else
							send_rx_byte(BYTE_W'($urandom_range(0, 255)));
					end
				end else begin
					repeat ($urandom_range(2, 4)) send_rx_byte(FLAG_BYTE);
				end
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (destuffed_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d counted bytes, %0d results, %0d frame ends matching length",
			counted, results_seen, ends_ok);
		$display("and %0d not matching, over %0d frame_length settings", ends_bad, cfg_writes);
		if (errors == 0)
			$display("flag_framed_byte_destuffer_tb: done, clean");
		else
			$display("flag_framed_byte_destuffer_tb: done, errors");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/fbd_pkg.sv
rtl/core/fbd_in_stage.sv
rtl/core/fbd_decode.sv
rtl/core/fbd_out_stage.sv
rtl/core/flag_framed_byte_destuffer.sv
tb/flag_framed_byte_destuffer_tb.sv
